// ----- src/fm_sine_voice_unit_macros.svh -----
`ifndef FM_SINE_VOICE_UNIT_MACROS_SVH
`define FM_SINE_VOICE_UNIT_MACROS_SVH

`ifndef SYNTH
// ante holds -> cons holds in the same cycle
`define FSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// ante holds -> cons holds in the next cycle
`define FSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FSV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/fsv_pkg.sv -----
package fsv_pkg;

  localparam int SLIDER_COUNT = 8;
  localparam int IDX_W        = 3;
  localparam int MUL_W        = 32;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int ACC_W        = 37;
  localparam int MAG_W        = 36;

  localparam logic [16:0] SIN_A      = 17'd102944;
  localparam logic [15:0] SIN_B      = 16'd42048;
  localparam logic [12:0] SIN_C      = 13'd4640;
  localparam logic [26:0] INV_PI_Q28 = 27'd85445659;

  localparam logic [14:0] BASE_HZ_RST     = 15'd220;
  localparam logic [14:0] SPAN_HZ_RST     = 15'd220;
  localparam logic [19:0] STEP_PER_HZ_RST = 20'd97391;

  typedef enum logic [1:0] {
    REG_BASE_HZ     = 2'd0,
    REG_SPAN_HZ     = 2'd1,
    REG_STEP_PER_HZ = 2'd2
  } reg_idx_e;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_Z     = 15'h0002,
    S_Z2    = 15'h0004,
    S_INNER = 15'h0008,
    S_P     = 15'h0010,
    S_MAG   = 15'h0020,
    S_ACC   = 15'h0040,
    S_ABS   = 15'h0080,
    S_OFF0  = 15'h0100,
    S_OFF1  = 15'h0200,
    S_OFF2  = 15'h0400,
    S_SAMP  = 15'h0800,
    S_INC0  = 15'h1000,
    S_INC1  = 15'h2000,
    S_INC2  = 15'h4000
  } state_e;

  typedef struct packed {
    logic [14:0] base_hz;
    logic [14:0] span_hz;
    logic [19:0] step_per_hz;
  } cfg_t;

  typedef struct packed {
    state_e           st;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] ang_idx;
    logic             car;
  } ctrl_t;

  // modulator ratio in quarters
  function automatic logic [4:0] ratio_q(input logic [IDX_W-1:0] idx);
    logic [4:0] r;
    case (idx)
      3'd0:    r = 5'd1;
      3'd1:    r = 5'd2;
      3'd2:    r = 5'd4;
      3'd3:    r = 5'd6;
      3'd4:    r = 5'd8;
      3'd5:    r = 5'd12;
      3'd6:    r = 5'd14;
      3'd7:    r = 5'd16;
      default: r = 5'd1;
    endcase
    return r;
  endfunction

  // fold a Q0.16 turn into the quarter, Q0.16 of a quarter turn
  function automatic logic [16:0] sine_fold(input logic [15:0] u);
    logic [14:0] r;
    r = {1'b0, u[13:0]};
    if (u[14]) begin
      r = 15'd16384 - r;
    end
    return {r, 2'b00};
  endfunction

endpackage

// ----- src/fsv_mul.sv -----
module fsv_mul (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [fsv_pkg::MUL_W-1:0]       a_i,
  input  logic [fsv_pkg::MUL_W-1:0]       b_i,
  output logic [2*fsv_pkg::MUL_W-1:0]     p_o
);
  import fsv_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- src/fsv_apb_regs.sv -----
module fsv_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsv_pkg::APB_AW-1:0]   paddr,
  input  logic [fsv_pkg::APB_DW-1:0]   pwdata,
  output logic [fsv_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output fsv_pkg::cfg_t                cfg_o
);
  import fsv_pkg::*;

  cfg_t     cfg_q;
  logic     wr;
  reg_idx_e sel;

  assign wr     = psel & penable & pwrite;
  assign sel    = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_hz     <= BASE_HZ_RST;
      cfg_q.span_hz     <= SPAN_HZ_RST;
      cfg_q.step_per_hz <= STEP_PER_HZ_RST;
    end else if (wr) begin
      case (sel)
        REG_BASE_HZ:     cfg_q.base_hz     <= pwdata[14:0];
        REG_SPAN_HZ:     cfg_q.span_hz     <= pwdata[14:0];
        REG_STEP_PER_HZ: cfg_q.step_per_hz <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_BASE_HZ:     prdata = APB_DW'(cfg_q.base_hz);
      REG_SPAN_HZ:     prdata = APB_DW'(cfg_q.span_hz);
      REG_STEP_PER_HZ: prdata = APB_DW'(cfg_q.step_per_hz);
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- src/fsv_seq.sv -----
`include "fm_sine_voice_unit_macros.svh"

module fsv_seq #(
  parameter int MOD_COUNT = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           slot_free_i,
  output fsv_pkg::ctrl_t ctrl_o
);
  import fsv_pkg::*;

  localparam int NUM_USED = (MOD_COUNT < SLIDER_COUNT) ? MOD_COUNT : SLIDER_COUNT;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_USED - 1);

  state_e           st_q, st_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             car_q, car_d;

  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    car_d = car_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d  = S_Z;
          idx_d = '0;
          car_d = 1'b0;
        end
      end
      S_Z:     st_d = S_Z2;
      S_Z2:    st_d = S_INNER;
      S_INNER: st_d = S_P;
      S_P:     st_d = S_MAG;
      S_MAG:   st_d = car_q ? S_SAMP : S_ACC;
      S_ACC: begin
        if (idx_q == LAST_IDX) begin
          st_d = S_ABS;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d  = S_Z;
        end
      end
      S_ABS:  st_d = S_OFF0;
      S_OFF0: st_d = S_OFF1;
      S_OFF1: st_d = S_OFF2;
      S_OFF2: begin
        st_d  = S_Z;
        car_d = 1'b1;
      end
      S_SAMP: begin
        if (slot_free_i) begin
          st_d = S_INC0;
        end
      end
      S_INC0:  st_d = S_INC1;
      S_INC1:  st_d = S_INC2;
      S_INC2:  st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      idx_q <= '0;
      car_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      car_q <= car_d;
    end
  end

  assign in_ready_o     = (st_q == S_IDLE);
  assign ctrl_o.st      = st_q;
  assign ctrl_o.idx     = idx_q;
  assign ctrl_o.ang_idx = (st_q == S_IDLE) ? '0 : idx_q + 1'b1;
  assign ctrl_o.car     = car_q;

  `FSV_ASSERT_IMP(a_idx_range, clk_i, rst_ni, 1'b1, idx_q <= LAST_IDX,
                  "modulator index past last")
  `FSV_ASSERT_NXT(a_accept_start, clk_i, rst_ni, in_valid_i && st_q == S_IDLE,
                  st_q == S_Z && idx_q == '0 && !car_q, "item did not start at first modulator")

endmodule

// ----- src/fm_sine_voice_unit.sv -----
// One sample per item; sine, offset and increment products share one 32x32 multiplier;
// the modulator angle scaling has its own multiply. A new item is accepted only in idle,
// after the previous one finishes; an unread output stalls the next item only at its end.
// Reset: both phases clear to zero, registers return to 220 Hz base, 220 Hz span, step 97391.
`include "fm_sine_voice_unit_macros.svh"

module fm_sine_voice_unit #(
  parameter int MOD_COUNT  = 8,
  parameter int PHASE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsv_pkg::APB_AW-1:0]   paddr,
  input  logic [fsv_pkg::APB_DW-1:0]   pwdata,
  output logic [fsv_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [15:0]                  volume_i,
  input  logic [15:0]                  pitch_knob_i,
  input  logic [15:0]                  slider_0_i,
  input  logic [15:0]                  slider_1_i,
  input  logic [15:0]                  slider_2_i,
  input  logic [15:0]                  slider_3_i,
  input  logic [15:0]                  slider_4_i,
  input  logic [15:0]                  slider_5_i,
  input  logic [15:0]                  slider_6_i,
  input  logic [15:0]                  slider_7_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           sample_o
);
  import fsv_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic               mul_en;
  logic [2*MUL_W-1:0] prod;

  logic [PHASE_BITS-1:0] car_q, mod_q;
  logic                  out_valid_q;
  logic signed [15:0]    sample_q;
  logic                  slot_free;

  logic [15:0] vol_q, knob_q;
  logic [15:0] sld_q [SLIDER_COUNT];
  logic [15:0] u_q;
  logic [16:0] z_q, z2_q;
  logic        neg_q, sneg_q;
  logic [ACC_W-1:0] acc_q;
  logic [MAG_W-1:0] sabs_q;
  logic [44:0]      lo_q;

  logic [PHASE_BITS+4:0] ang_prod;
  logic [15:0]           ang_u;
  logic [16:0]           z_fold, z2_w, p_w, mag_w;
  logic [15:0]           inner_w, level_w;
  logic [32:0]           term_w;
  logic [63:0]           tot_w;
  logic [PHASE_BITS-1:0] off_w, offs_w, ph_w, inc_w;
  logic [31:0]           freq_w;
  logic [14:0]           v_w;
  logic [15:0]           samp_w;

  fsv_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsv_seq #(
    .MOD_COUNT (MOD_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .slot_free_i (slot_free),
    .ctrl_o      (ctrl)
  );

  fsv_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  assign ang_prod = (PHASE_BITS+5)'(mod_q) * (PHASE_BITS+5)'(ratio_q(ctrl.ang_idx));
  assign ang_u    = ang_prod[PHASE_BITS+1 -: 16];

  assign z_fold  = sine_fold(u_q);
  assign z2_w    = prod[32:16];
  assign inner_w = SIN_B - prod[31:16];
  assign p_w     = SIN_A - {1'b0, prod[31:16]};
  assign mag_w   = prod[32:16];
  assign level_w = ctrl.car ? vol_q : sld_q[ctrl.idx];
  assign term_w  = prod[32:0];

  assign tot_w  = 64'(lo_q) + {1'b0, prod[44:0], 18'h0};
  assign off_w  = tot_w[59 -: PHASE_BITS];
  assign offs_w = sneg_q ? PHASE_BITS'(-off_w) : off_w;
  assign ph_w   = car_q + offs_w;

  assign freq_w = 32'({cfg.base_hz, 16'h0}) + 32'(prod[30:0]);
  assign inc_w  = PHASE_BITS'(prod >> 16);

  assign v_w    = prod[32] ? 15'h7FFF : prod[31:17];
  assign samp_w = neg_q ? 16'(16'd0 - {1'b0, v_w}) : {1'b0, v_w};

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (ctrl.st)
      S_Z: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(z_fold);
        mul_b  = MUL_W'(z_fold);
      end
      S_Z2: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(z2_w);
        mul_b  = MUL_W'(SIN_C);
      end
      S_INNER: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(z2_q);
        mul_b  = MUL_W'(inner_w);
      end
      S_P: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(z_q);
        mul_b  = MUL_W'(p_w);
      end
      S_MAG: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(mag_w);
        mul_b  = MUL_W'(level_w);
      end
      S_OFF0: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(sabs_q[17:0]);
        mul_b  = MUL_W'(INV_PI_Q28);
      end
      S_OFF1: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(sabs_q[MAG_W-1:18]);
        mul_b  = MUL_W'(INV_PI_Q28);
      end
      S_INC0: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(cfg.span_hz);
        mul_b  = MUL_W'(knob_q);
      end
      S_INC1: begin
        mul_en = 1'b1;
        mul_a  = freq_w;
        mul_b  = MUL_W'(cfg.step_per_hz);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (ctrl.st)
      S_IDLE: begin
        if (in_valid_i) begin
          vol_q    <= volume_i;
          knob_q   <= pitch_knob_i;
          sld_q[0] <= slider_0_i;
          sld_q[1] <= slider_1_i;
          sld_q[2] <= slider_2_i;
          sld_q[3] <= slider_3_i;
          sld_q[4] <= slider_4_i;
          sld_q[5] <= slider_5_i;
          sld_q[6] <= slider_6_i;
          sld_q[7] <= slider_7_i;
          acc_q    <= '0;
          u_q      <= ang_u;
        end
      end
      S_Z: begin
        z_q   <= z_fold;
        neg_q <= u_q[15];
      end
      S_Z2: z2_q <= z2_w;
      S_ACC: begin
        acc_q <= neg_q ? acc_q - ACC_W'(term_w) : acc_q + ACC_W'(term_w);
        u_q   <= ang_u;
      end
      S_ABS: begin
        sneg_q <= acc_q[ACC_W-1];
        sabs_q <= acc_q[ACC_W-1] ? MAG_W'(-acc_q) : acc_q[MAG_W-1:0];
      end
      S_OFF1: lo_q <= prod[44:0];
      S_OFF2: u_q <= ph_w[PHASE_BITS-1 -: 16];
      S_SAMP: begin
        if (slot_free) begin
          sample_q <= samp_w;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q       <= '0;
      mod_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.st == S_INC2) begin
        car_q <= car_q + inc_w;
        mod_q <= mod_q + inc_w;
      end
      if (ctrl.st == S_SAMP && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  `FSV_ASSERT_IMP(a_phase_lock, clk_i, rst_ni, 1'b1, car_q == mod_q,
                  "carrier and modulator phases diverged")
  `FSV_ASSERT_IMP(a_out_from_samp, clk_i, rst_ni, $rose(out_valid_q),
                  $past(ctrl.st == S_SAMP), "output valid rose outside sample step")
  `FSV_ASSERT_IMP(a_phase_step, clk_i, rst_ni, !$stable(car_q),
                  $past(ctrl.st == S_INC2), "phase moved outside increment step")

endmodule
